// ===== hw/rtl/cers_pkg.sv =====
// shared constants, item types and elaboration-time helper functions
// for the compton energy rejection sampler; no dependencies
package cers_pkg;

  localparam int FB  = 30;             // fraction bits of eps and 1-cos
  localparam int RB  = 32;             // random fraction bits
  localparam int EW  = 48;             // photon energy width
  localparam int SCW = 55;             // width of energy in centi-eV
  localparam int DNW = 56;             // width of m + 200 E
  localparam int MW  = 26;             // width of electron mass in centi-eV
  localparam int LGW = $clog2(DNW) + FB;

  localparam logic [MW-1:0] MASS = 26'd51099895;
  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};
  localparam logic [FB+1:0] TWO = {2'b10, {FB{1'b0}}};

  typedef struct packed {
    logic [EW-1:0] photon_energy;
    logic [RB-1:0] uniform_one;
    logic [RB-1:0] uniform_two;
    logic [RB-1:0] uniform_three;
  } request_t;

  typedef struct packed {
    logic          accepted;
    logic [30:0]   energy_ratio;
    logic [31:0]   one_minus_cosine;
    logic [31:0]   sine_squared;
  } result_t;

  // log2 of an integer by repeated squaring of the mantissa
  function automatic logic [63:0] log2_fixed(input logic [63:0] n);
    logic [63:0] mant;
    logic [63:0] frac;
    int          top;
    top = 0;
    for (int i = 0; i < 64; i++) begin
      if (n[i]) top = i;
    end
    if (top >= FB) mant = n >> (top - FB);
    else mant = n << (FB - top);
    frac = '0;
    for (int i = 1; i <= FB; i++) begin
      mant = (mant * mant) >> FB;
      if (mant >= (64'd2 << FB)) begin
        mant = mant >> 1;
        frac[FB-i] = 1'b1;
      end
    end
    return (64'(top) << FB) | frac;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (v >= t * t) r = t;
    end
    return r;
  endfunction

  // 2^(-2^-j): repeated square roots starting from one half
  function automatic logic [FB-1:0] exp_root(input int j);
    logic [63:0] root;
    root = 64'd1 << (FB - 1);
    for (int k = 1; k <= j; k++) begin
      root = isqrt64(root << FB);
    end
    return root[FB-1:0];
  endfunction

  localparam logic [LGW-1:0] LOG2_MASS = LGW'(log2_fixed(64'(MASS)));

endpackage

// ===== hw/rtl/cers_if.sv =====
// valid/ready channel carrying one payload type
// no dependencies; payload type comes from cers_pkg at instantiation
interface cers_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cers_log2.sv =====
// pipelined fixed-point log2: leading-one search then one squaring per stage
// depends on cers_pkg
module cers_log2 #(
  parameter int NW = cers_pkg::DNW,
  parameter int SIDE_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [NW-1:0]                     in_value,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  output logic [$clog2(NW)+cers_pkg::FB-1:0] out_lg,
  output logic [SIDE_W-1:0]                 out_side
);
  localparam int FB = cers_pkg::FB;
  localparam int TW = $clog2(NW);

  logic              v    [0:FB];
  logic [SIDE_W-1:0] side [0:FB];
  logic [TW-1:0]     topr [0:FB];
  logic [FB:0]       mant [0:FB];
  logic [FB-1:0]     frac [0:FB];

  logic [TW-1:0] top_c;
  logic [NW-1:0] shl;
  logic [NW-1:0] shr;

  always_comb begin
    top_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (in_value[i]) top_c = TW'(i);
    end
    shr = in_value >> (top_c - TW'(FB));
    shl = in_value << (TW'(FB) - top_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      topr[0] <= top_c;
      mant[0] <= (top_c >= TW'(FB)) ? shr[FB:0] : shl[FB:0];
      frac[0] <= '0;
    end
  end

  for (genvar s = 1; s <= FB; s++) begin : g_sq
    logic [2*FB+1:0] sq;
    logic [FB+1:0]   m2;
    logic [FB-1:0]   fn;

    always_comb begin
      sq = (2*FB+2)'(mant[s-1]) * (2*FB+2)'(mant[s-1]);
      m2 = sq[2*FB+1:FB];
      fn = frac[s-1];
      fn[FB-s] = m2[FB+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= side[s-1];
        topr[s] <= topr[s-1];
        mant[s] <= m2[FB+1] ? m2[FB+1:1] : m2[FB:0];
        frac[s] <= fn;
      end
    end
  end

  assign out_valid = v[FB];
  assign out_side  = side[FB];
  assign out_lg    = {topr[FB], frac[FB]};
endmodule

// ===== hw/rtl/cers_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on nothing beyond its parameters
module cers_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NW-1:0]     in_num,
  input  logic [DW-1:0]     in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic              out_over,
  output logic [SIDE_W-1:0] out_side
);
  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic              v    [0:QW];
  logic [SIDE_W-1:0] side [0:QW];
  logic [W-1:0]      rem  [0:QW];
  logic [DW-1:0]     den  [0:QW];
  logic [QW-1:0]     quo  [0:QW];
  logic              over [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      rem[0]  <= W'(in_num);
      den[0]  <= in_den;
      quo[0]  <= '0;
      over[0] <= W'(in_num) >= W'({in_den, {QW{1'b0}}});
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int B = QW - s;
    logic [W-1:0]  sub;
    logic          ge;
    logic [QW-1:0] qn;

    always_comb begin
      sub = W'(den[s-1]) << B;
      ge  = rem[s-1] >= sub;
      qn  = quo[s-1];
      qn[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= side[s-1];
        rem[s]  <= ge ? rem[s-1] - sub : rem[s-1];
        den[s]  <= den[s-1];
        quo[s]  <= qn;
        over[s] <= over[s-1];
      end
    end
  end

  assign out_valid = v[QW];
  assign out_quo   = quo[QW];
  assign out_over  = over[QW];
  assign out_side  = side[QW];
endmodule

// ===== hw/rtl/cers_exp2.sv =====
// pipelined 2^(-x): one conditional multiply by a root constant per stage
// depends on cers_pkg
module cers_exp2 #(
  parameter int XW = cers_pkg::LGW,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [XW-1:0]         in_x,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [cers_pkg::FB:0] out_ratio,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int FB = cers_pkg::FB;
  localparam int WW = XW - FB;

  logic              v     [0:FB];
  logic [SIDE_W-1:0] side  [0:FB];
  logic [WW-1:0]     whole [0:FB];
  logic [FB-1:0]     frac  [0:FB];
  logic [FB:0]       res   [0:FB];

  logic              fin_valid;
  logic [SIDE_W-1:0] fin_side;
  logic [FB:0]       fin_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0]  <= in_side;
      whole[0] <= in_x[XW-1:FB];
      frac[0]  <= in_x[FB-1:0];
      res[0]   <= cers_pkg::ONE;
    end
  end

  for (genvar j = 1; j <= FB; j++) begin : g_mul
    localparam logic [FB-1:0] ROOT = cers_pkg::exp_root(j);
    logic [2*FB:0] prod;

    assign prod = (2*FB+1)'(res[j-1]) * (2*FB+1)'(ROOT);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j]  <= side[j-1];
        whole[j] <= whole[j-1];
        frac[j]  <= frac[j-1];
        res[j]   <= frac[j-1][FB-j] ? prod[2*FB:FB] : res[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= v[FB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_side  <= side[FB];
      fin_ratio <= (whole[FB] > WW'(FB)) ? '0 : res[FB] >> whole[FB];
    end
  end

  assign out_valid = fin_valid;
  assign out_side  = fin_side;
  assign out_ratio = fin_ratio;
endmodule

// ===== hw/rtl/cers_sqrt.sv =====
// pipelined truncated integer square root, one result bit per stage
// depends on nothing beyond its parameters
module cers_sqrt #(
  parameter int VW = 61,
  parameter int RW = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [VW-1:0]     in_value,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int CW = (VW > 2 * RW) ? VW : 2 * RW;

  logic              v    [0:RW];
  logic [SIDE_W-1:0] side [0:RW];
  logic [VW-1:0]     val  [0:RW];
  logic [RW-1:0]     root [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      val[0]  <= in_value;
      root[0] <= '0;
    end
  end

  for (genvar s = 1; s <= RW; s++) begin : g_bit
    localparam int B = RW - s;
    logic [RW-1:0]   t;
    logic [2*RW-1:0] tt;

    always_comb begin
      t = root[s-1];
      t[B] = 1'b1;
      tt = (2*RW)'(t) * (2*RW)'(t);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en) begin
        v[s] <= v[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= side[s-1];
        val[s]  <= val[s-1];
        root[s] <= (CW'(val[s-1]) >= CW'(tt)) ? t : root[s-1];
      end
    end
  end

  assign out_valid = v[RW];
  assign out_root  = root[RW];
  assign out_side  = side[RW];
endmodule

// ===== hw/rtl/compton_energy_rejection_sampler.sv =====
// top level of the compton energy rejection sampler: one klein-nishina attempt per transaction
// depends on cers_pkg, cers_if, cers_log2, cers_div, cers_exp2, cers_sqrt
//
//   channel   dir   payload               handshake
//   request   in    cers_pkg::request_t   valid/ready, taken when both high
//   result    out   cers_pkg::result_t    valid/ready, taken when both high
//
// one transaction enters per cycle while the skid is empty; each result is
// computed by a chain of bit-per-stage units (log2, two quotient dividers,
// exp2, square root and the final divider)
// rst is synchronous and clears only the valid bits of the pipeline and output
// the whole pipeline advances on one enable; a two-entry output register and
// skid let the request side keep moving while one result waits to be taken
module compton_energy_rejection_sampler (
  input logic   clk,
  input logic   rst,
  cers_if.sink   request,
  cers_if.source result
);
  localparam int FB    = cers_pkg::FB;
  localparam int RB    = cers_pkg::RB;
  localparam int SCW   = cers_pkg::SCW;
  localparam int DNW   = cers_pkg::DNW;
  localparam int MW    = cers_pkg::MW;
  localparam int LGW   = cers_pkg::LGW;
  localparam int SPLIT = 28;                      // split of the scaled energy product
  localparam int PW    = LGW + 32;                // lg times 32-bit constant or random
  localparam int LHW   = LGW + 1 + RB + 1;        // branch compare width
  localparam int UW    = FB + 1 + RB;
  localparam int DDW   = FB + 1 + SCW;            // eps times scaled energy
  localparam int NNW   = FB + 1 + MW;
  localparam int TNW   = FB + 1 + 32;

  // stage payloads
  typedef struct packed {
    logic           zero;
    logic [SCW-1:0] scaled;
    logic [DNW-1:0] denom;
    logic [RB-1:0]  ra;
    logic [RB-1:0]  rb;
    logic [RB-1:0]  rc;
  } a_t;

  typedef struct packed {
    logic           zero;
    logic [SCW-1:0] scaled;
    logic [LGW-1:0] lg;
    logic [RB-1:0]  ra;
    logic [RB-1:0]  rb;
    logic [RB-1:0]  rc;
  } b_t;

  typedef struct packed {
    logic           zero;
    logic [SCW-1:0] scaled;
    logic [RB-1:0]  rc;
    logic           first;
    logic [FB:0]    r2b;
  } c_t;

  typedef struct packed {
    c_t          c;
    logic [FB:0] ratio_a;
  } d_t;

  typedef struct packed {
    logic          zero;
    logic [RB-1:0] rc;
    logic [FB:0]   ratio;
    logic [FB:0]   ratio2;
  } e_t;

  typedef struct packed {
    logic          zero;
    logic [RB-1:0] rc;
    logic [FB:0]   ratio;
    logic [FB:0]   ratio2;
    logic [31:0]   omc;
    logic [31:0]   s2;
  } f_t;

  logic en;
  logic out_valid;
  logic skid_valid;
  cers_pkg::result_t out_data;
  cers_pkg::result_t skid_data;

  // pipeline only moves while the skid is empty
  assign en = !skid_valid;
  assign request.ready = en;

  // stage a: energy scaling to centi-eV and the log/divide operand m + 200 E
  logic           a_valid;
  a_t             a;
  logic [SCW-1:0] scaled_c;

  assign scaled_c = SCW'(request.data.photon_energy) * SCW'(100);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a.zero   <= request.data.photon_energy == '0;
      a.scaled <= scaled_c;
      a.denom  <= DNW'(cers_pkg::MASS) + {scaled_c, 1'b0};
      a.ra     <= request.data.uniform_one;
      a.rb     <= request.data.uniform_two;
      a.rc     <= request.data.uniform_three;
    end
  end

  // log2(1 + 2 kappa) = log2(m + 200 E) - log2(m)
  logic                 l_valid;
  logic [LGW-1:0]       lg_a;
  logic [$bits(a_t)-1:0] l_bits;
  a_t                   l_side;
  b_t                   b_in;

  cers_log2 #(.NW(DNW), .SIDE_W($bits(a_t))) u_log2 (
    .clk, .rst, .en,
    .in_valid (a_valid),
    .in_value (a.denom),
    .in_side  (a),
    .out_valid(l_valid),
    .out_lg   (lg_a),
    .out_side (l_bits)
  );

  assign l_side = a_t'(l_bits);

  always_comb begin
    b_in.zero   = l_side.zero;
    b_in.scaled = l_side.scaled;
    b_in.lg     = (lg_a > cers_pkg::LOG2_MASS) ? lg_a - cers_pkg::LOG2_MASS : '0;
    b_in.ra     = l_side.ra;
    b_in.rb     = l_side.rb;
    b_in.rc     = l_side.rc;
  end

  // eps0 = m 2^F / (m + 200 E)
  logic                  r_valid;
  logic [FB:0]           rmin_q;
  logic                  rmin_over;
  logic [$bits(b_t)-1:0] r_bits;
  b_t                    r_side;

  cers_div #(.NW(MW + FB), .DW(DNW), .QW(FB + 1), .SIDE_W($bits(b_t))) u_div_eps0 (
    .clk, .rst, .en,
    .in_valid (l_valid),
    .in_num   ({cers_pkg::MASS, {FB{1'b0}}}),
    .in_den   (l_side.denom),
    .in_side  (b_in),
    .out_valid(r_valid),
    .out_quo  (rmin_q),
    .out_over (rmin_over),
    .out_side (r_bits)
  );

  assign r_side = b_t'(r_bits);

  // m1: eps0 clamp and square, lg times ln2 halves, lg times r2
  logic          m1_valid;
  b_t            m1;
  logic [FB:0]   m1_rmin2;
  logic [PW-1:0] m1_hi;
  logic [PW-1:0] m1_lo;
  logic [PW-1:0] m1_xp;
  logic [FB:0]   rmin_c;
  logic [2*FB+1:0] rmin_sq;

  assign rmin_c  = (rmin_over || rmin_q > cers_pkg::ONE) ? cers_pkg::ONE : rmin_q;
  assign rmin_sq = (2*FB+2)'(rmin_c) * (2*FB+2)'(rmin_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1       <= r_side;
      m1_rmin2 <= rmin_sq[2*FB:FB];
      m1_hi    <= PW'(r_side.lg) * PW'(cers_pkg::LN2_Q64[63:32]);
      m1_lo    <= PW'(r_side.lg) * PW'(cers_pkg::LN2_Q64[31:0]);
      m1_xp    <= PW'(r_side.lg) * PW'(r_side.rb);
    end
  end

  // m2: a1 = lg ln2, and (1 - eps0^2) r2 for the second branch
  logic           m2_valid;
  b_t             m2;
  logic [FB:0]    m2_rmin2;
  logic [LGW-1:0] m2_lnv;
  logic [UW-1:0]  m2_u;
  logic [LGW-1:0] m2_x;
  logic [PW-1:0]  lnv_sum;

  assign lnv_sum = m1_hi + (m1_lo >> 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2       <= m1;
      m2_rmin2 <= m1_rmin2;
      m2_lnv   <= lnv_sum[PW-1:32];
      m2_u     <= UW'(cers_pkg::ONE - m1_rmin2) * UW'(m1.rb);
      m2_x     <= m1_xp[PW-1:32];
    end
  end

  // m3: cross-multiplied branch test operands and the branch-two eps^2
  logic           m3_valid;
  b_t             m3;
  logic [LHW-1:0] m3_lhs;
  logic [LHW-1:0] m3_rhs;
  logic [FB:0]    m3_r2b;
  logic [LGW-1:0] m3_x;
  logic [FB+1:0]  r2_sum;

  assign r2_sum = (FB+2)'(m2_rmin2) + (FB+2)'(m2_u[UW-1:RB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else if (en) begin
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3     <= m2;
      m3_lhs <= LHW'({m2_lnv, 1'b0}) * LHW'({1'b1, {RB{1'b0}}} - (RB+1)'(m2.ra));
      m3_rhs <= LHW'(m2.ra) * LHW'(cers_pkg::ONE - m2_rmin2);
      m3_r2b <= (r2_sum > (FB+2)'(cers_pkg::ONE)) ? cers_pkg::ONE : r2_sum[FB:0];
      m3_x   <= m2_x;
    end
  end

  // branch one: eps = 2^(-lg r2)
  c_t                    c_in;
  logic                  x_valid;
  logic [FB:0]           ratio_a;
  logic [$bits(c_t)-1:0] x_bits;
  c_t                    x_side;
  d_t                    d_in;

  always_comb begin
    c_in.zero   = m3.zero;
    c_in.scaled = m3.scaled;
    c_in.rc     = m3.rc;
    c_in.first  = m3_rhs < m3_lhs;
    c_in.r2b    = m3_r2b;
  end

  cers_exp2 #(.XW(LGW), .SIDE_W($bits(c_t))) u_exp2 (
    .clk, .rst, .en,
    .in_valid (m3_valid),
    .in_x     (m3_x),
    .in_side  (c_in),
    .out_valid(x_valid),
    .out_ratio(ratio_a),
    .out_side (x_bits)
  );

  assign x_side    = c_t'(x_bits);
  assign d_in.c       = x_side;
  assign d_in.ratio_a = ratio_a;

  // branch two: eps = sqrt(eps^2)
  logic                  q_valid;
  logic [FB:0]           ratio_b;
  logic [$bits(d_t)-1:0] q_bits;
  d_t                    q_side;

  cers_sqrt #(.VW(2 * FB + 1), .RW(FB + 1), .SIDE_W($bits(d_t))) u_sqrt (
    .clk, .rst, .en,
    .in_valid (x_valid),
    .in_value ({x_side.r2b, {FB{1'b0}}}),
    .in_side  (d_in),
    .out_valid(q_valid),
    .out_root (ratio_b),
    .out_side (q_bits)
  );

  assign q_side = d_t'(q_bits);

  // s: branch select, eps held within one ulp and one
  logic        s_valid;
  c_t          s_side;
  logic [FB:0] s_ratio;
  logic [FB:0] ratio_sel;

  assign ratio_sel = q_side.c.first ? q_side.ratio_a : ratio_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side <= q_side.c;
      if (ratio_sel > cers_pkg::ONE) begin
        s_ratio <= cers_pkg::ONE;
      end else if (ratio_sel == '0) begin
        s_ratio <= (FB+1)'(1);
      end else begin
        s_ratio <= ratio_sel;
      end
    end
  end

  // p1: eps^2 on branch one, partial products of eps times scaled energy, and (1-eps) m
  logic              p1_valid;
  e_t                p1;
  logic [FB+SPLIT:0] p1_pa;
  logic [DDW-SPLIT-1:0] p1_pb;
  logic [NNW-1:0]    p1_nn;
  logic [2*FB+1:0]   ratio_sq;

  assign ratio_sq = (2*FB+2)'(s_ratio) * (2*FB+2)'(s_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1.zero   <= s_side.zero;
      p1.rc     <= s_side.rc;
      p1.ratio  <= s_ratio;
      p1.ratio2 <= s_side.first ? ratio_sq[2*FB:FB] : s_side.r2b;
      p1_pa     <= (FB+SPLIT+1)'(s_ratio) * (FB+SPLIT+1)'(s_side.scaled[SPLIT-1:0]);
      p1_pb     <= (DDW-SPLIT)'(s_ratio) * (DDW-SPLIT)'(s_side.scaled[SCW-1:SPLIT]);
      p1_nn     <= NNW'(cers_pkg::ONE - s_ratio) * NNW'(cers_pkg::MASS);
    end
  end

  // p2: divider operands for 1-cos = (1-eps) m / (eps 100 E)
  logic           p2_valid;
  e_t             p2;
  logic [DDW-1:0] p2_den;
  logic [NNW-1:0] p2_nn;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2     <= p1;
      p2_den <= DDW'(p1_pa) + (DDW'(p1_pb) << SPLIT);
      p2_nn  <= p1_nn;
    end
  end

  logic                  o_valid_d;
  logic [31:0]           omc_q;
  logic                  omc_over;
  logic [$bits(e_t)-1:0] o_bits;
  e_t                    o_side;

  cers_div #(.NW(NNW + FB), .DW(DDW), .QW(32), .SIDE_W($bits(e_t))) u_div_omc (
    .clk, .rst, .en,
    .in_valid (p2_valid),
    .in_num   ({p2_nn, {FB{1'b0}}}),
    .in_den   (p2_den),
    .in_side  (p2),
    .out_valid(o_valid_d),
    .out_quo  (omc_q),
    .out_over (omc_over),
    .out_side (o_bits)
  );

  assign o_side = e_t'(o_bits);

  // o: 1-cos held at 2, sin^2 = (1-cos)(2-(1-cos))
  logic        o_valid;
  f_t          o;
  logic [31:0] omc_c;
  logic [63:0] s2_prod;

  assign omc_c   = (omc_over || omc_q > cers_pkg::TWO) ? cers_pkg::TWO : omc_q;
  assign s2_prod = 64'(omc_c) * 64'(cers_pkg::TWO - omc_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= o_valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o.zero   <= o_side.zero;
      o.rc     <= o_side.rc;
      o.ratio  <= o_side.ratio;
      o.ratio2 <= o_side.ratio2;
      o.omc    <= omc_c;
      o.s2     <= s2_prod[FB+30:FB-1];
    end
  end

  // t: operands of eps sin^2 / (2 (1 + eps^2))
  logic           t_valid;
  f_t             t;
  logic [TNW-1:0] t_num;
  logic [FB+2:0]  t_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (en) begin
      t_valid <= o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t     <= o;
      t_num <= TNW'(o.ratio) * TNW'(o.s2);
      t_den <= {(FB+2)'(cers_pkg::ONE) + (FB+2)'(o.ratio2), 1'b0};
    end
  end

  logic                  g_valid;
  logic [FB:0]           g_t;
  logic                  g_over;
  logic [$bits(f_t)-1:0] g_bits;
  f_t                    g_side;

  cers_div #(.NW(TNW), .DW(FB + 3), .QW(FB + 1), .SIDE_W($bits(f_t))) u_div_g (
    .clk, .rst, .en,
    .in_valid (t_valid),
    .in_num   (t_num),
    .in_den   (t_den),
    .in_side  (t),
    .out_valid(g_valid),
    .out_quo  (g_t),
    .out_over (g_over),
    .out_side (g_bits)
  );

  assign g_side = f_t'(g_bits);

  // acceptance: g = 1 - t beats r3, i.e. r3 < (1 - t) 2^(R-F)
  cers_pkg::result_t res_c;
  logic [FB+2:0]     g_lim;
  logic              acc_c;

  always_comb begin
    g_lim = {cers_pkg::ONE - g_t, 2'b00};
    acc_c = !g_over && (g_t < cers_pkg::ONE) && ((FB+3)'(g_side.rc) < g_lim);
    res_c.accepted         = g_side.zero | acc_c;
    res_c.energy_ratio     = g_side.zero ? cers_pkg::ONE : g_side.ratio;
    res_c.one_minus_cosine = g_side.zero ? '0 : g_side.omc;
    res_c.sine_squared     = g_side.zero ? '0 : g_side.s2;
  end

  // output register with skid: the skid only fills when the output is held
  logic take_out;

  assign take_out = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take_out) begin
        skid_valid <= 1'b0;
      end
    end else if (g_valid) begin
      if (out_valid && !take_out) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take_out) begin
        out_data <= skid_data;
      end
    end else if (g_valid) begin
      if (out_valid && !take_out) begin
        skid_data <= res_c;
      end else begin
        out_data <= res_c;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef ASSERT_OFF
  a_skid_behind_output : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transaction while the output register is empty");

  a_skid_fill_cause : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready && g_valid))
    else $error("skid filled without a held output and an arriving result");

  a_result_ranges : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.data.one_minus_cosine <= cers_pkg::TWO &&
                      result.data.sine_squared <= cers_pkg::TWO &&
                      result.data.energy_ratio != '0))
    else $error("result field out of its range");
`endif
endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the compton energy rejection sampler
// depends on cers_pkg, cers_if and the sampler top level
`timescale 1ns / 100ps

module tb_top;
  localparam int FB = cers_pkg::FB;
  localparam int RB = cers_pkg::RB;
  localparam int EW = cers_pkg::EW;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 260;   // longer than the pipeline latency
  localparam int LONG_HOLD    = 400;   // long enough to fill pipeline and skid
  localparam int N_RANDOM     = 700;
  localparam logic [63:0] FX1 = 64'd1 << FB;
  localparam logic [63:0] MASS64 = 64'(cers_pkg::MASS);
  localparam logic [63:0] ALL_ONES = '1;

  logic clk;
  logic rst;

  cers_if #(.payload_t(cers_pkg::request_t)) request ();
  cers_if #(.payload_t(cers_pkg::result_t))  result ();

  compton_energy_rejection_sampler dut (
    .clk(clk),
    .rst(rst),
    .request(request),
    .result(result)
  );

  typedef struct {
    cers_pkg::request_t req;
    bit                 known;   // expected result typed in rather than predicted
    cers_pkg::result_t  res;
  } stim_row_t;

  cers_pkg::result_t pending_samples[$];
  int                mismatches;
  int                cycle_count;
  bit                long_hold_req;
  stim_row_t         stim_table[$];

  // ---------------------------------------------------------------------
  // fixed-point arithmetic of the sampler, all truncating
  // ---------------------------------------------------------------------

  // (a*b) >> s, saturated to 64 bits
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> s;
    return (p[127:64] != 0) ? ALL_ONES : p[63:0];
  endfunction

  // floor(x * 2^extra / d), saturated to 64 bits; zero divisor saturates
  function automatic logic [63:0] div_scaled(input logic [127:0] x, input int extra,
                                             input logic [127:0] d);
    logic [191:0] q;
    if (d == 0) return ALL_ONES;
    q = (192'(x) << extra) / 192'(d);
    return (q[191:64] != 0) ? ALL_ONES : q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (v >= 128'(t) * 128'(t)) r = t;
    end
    return r;
  endfunction

  // leading-one position plus fraction bits by squaring the mantissa
  function automatic logic [63:0] log2_q(input logic [63:0] n);
    int          top;
    logic [63:0] mant;
    logic [63:0] frac;
    if (n == 0) return 0;
    top = 0;
    for (int i = 0; i < 64; i++) begin
      if (n[i]) top = i;
    end
    if (top >= FB) mant = n >> (top - FB);
    else mant = n << (FB - top);
    frac = '0;
    for (int i = 1; i <= FB; i++) begin
      mant = mul_shift(mant, mant, FB);
      if (mant >= 2 * FX1) begin
        mant = mant >> 1;
        frac[FB-i] = 1'b1;
      end
    end
    return (64'(top) << FB) | frac;
  endfunction

  // 2^(-x) from per-bit factors, each a square root of the one before
  function automatic logic [63:0] pow2_neg(input logic [63:0] x);
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] res;
    logic [63:0] root;
    whole = x >> FB;
    frac  = x & (FX1 - 1);
    res   = FX1;
    root  = FX1 >> 1;
    if (whole > FB) return 0;
    for (int j = 1; j <= FB; j++) begin
      root = int_sqrt(128'(root) * 128'(FX1));
      if (frac[FB-j]) res = mul_shift(res, root, FB);
    end
    return res >> whole;
  endfunction

  // one klein-nishina attempt, bit for bit
  function automatic cers_pkg::result_t predict_sample(input cers_pkg::request_t rq);
    logic [63:0] energy, ra, rb, rc;
    logic [63:0] scaled, denom, lg_a, lg_b, lg, lnv, rmin, rmin2;
    logic [63:0] ratio, ratio2, omc, s2, t;
    logic [127:0] lhs, rhs;
    bit          first, acc;
    cers_pkg::result_t r;
    energy = 64'(rq.photon_energy);
    ra = 64'(rq.uniform_one);
    rb = 64'(rq.uniform_two);
    rc = 64'(rq.uniform_three);
    if (energy == 0) begin
      r.accepted = 1'b1;
      r.energy_ratio = 31'(FX1);
      r.one_minus_cosine = '0;
      r.sine_squared = '0;
      return r;
    end
    scaled = 64'd100 * energy;
    denom  = MASS64 + 2 * scaled;
    lg_a   = log2_q(denom);
    lg_b   = log2_q(MASS64);
    lg     = (lg_a > lg_b) ? lg_a - lg_b : 64'd0;
    lnv    = mul_shift(lg, cers_pkg::LN2_Q64, 64);
    rmin   = div_scaled(128'(MASS64), FB, 128'(denom));
    if (rmin > FX1) rmin = FX1;
    rmin2  = mul_shift(rmin, rmin, FB);

    // branch choice by cross-multiplied compare
    lhs   = 128'(64'(2 * lnv)) * 128'((64'd1 << RB) - ra);
    rhs   = 128'(ra) * 128'(FX1 - rmin2);
    first = rhs < lhs;

    if (first) begin
      ratio  = pow2_neg(mul_shift(lg, rb, RB));
      ratio2 = 0;
    end else begin
      ratio2 = rmin2 + mul_shift(FX1 - rmin2, rb, RB);
      if (ratio2 > FX1) ratio2 = FX1;
      ratio  = int_sqrt(128'(ratio2) * 128'(FX1));
    end
    if (ratio > FX1) ratio = FX1;
    if (ratio == 0) ratio = 1;
    if (first) ratio2 = mul_shift(ratio, ratio, FB);

    omc = div_scaled(128'(FX1 - ratio) * 128'(MASS64), FB, 128'(ratio) * 128'(scaled));
    if (omc > 2 * FX1) omc = 2 * FX1;
    s2  = mul_shift(omc, 2 * FX1 - omc, FB - 1);

    t   = div_scaled(128'(ratio) * 128'(s2), 0, 128'(64'(2 * (FX1 + ratio2))));
    acc = (t < FX1) &&
          !((128'(rc) * 128'(FX1)) >= (128'(FX1 - t) * 128'(64'd1 << RB)));

    r.accepted = acc;
    r.energy_ratio = ratio[30:0];
    r.one_minus_cosine = omc[31:0];
    r.sine_squared = s2[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // result side: random back-pressure, one long hold on request
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    result.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // starve the output so the pipeline fills and request stalls
        result.ready <= 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  // compare each completed result transaction with the oldest prediction
  always @(posedge clk) begin
    cers_pkg::result_t exp_r;
    if (!rst && result.valid && result.ready) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result.data);
      end else begin
        exp_r = pending_samples.pop_front();
        if (result.data.accepted !== exp_r.accepted ||
            result.data.energy_ratio !== exp_r.energy_ratio ||
            result.data.one_minus_cosine !== exp_r.one_minus_cosine ||
            result.data.sine_squared !== exp_r.sine_squared) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", exp_r, result.data);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // offer one request transaction after a random gap and wait for it to go
  task automatic offer_request(input cers_pkg::request_t rq, input cers_pkg::result_t exp_r);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.data  <= rq;
    do @(posedge clk); while (!request.ready);
    pending_samples.insert(pending_samples.size(), exp_r);
  endtask

  task automatic wait_for_drain();
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // log-uniform energy so that every decade of kappa is visited
  function automatic logic [EW-1:0] draw_energy();
    logic [EW-1:0] e;
    int            sh;
    e  = EW'({$urandom, $urandom});
    sh = $urandom_range(0, EW - 1);
    e  = e >> sh;
    if (e == 0) e = 1;
    return e;
  endfunction

  function automatic stim_row_t mk_row(input logic [EW-1:0] e, input logic [RB-1:0] a,
                                       input logic [RB-1:0] b, input logic [RB-1:0] c);
    stim_row_t s;
    s.req = '{photon_energy: e, uniform_one: a, uniform_two: b, uniform_three: c};
    s.known = 1'b0;
    s.res = '0;
    return s;
  endfunction

  function automatic void add_row(input stim_row_t r);
    stim_table.insert(stim_table.size(), r);
  endfunction

  initial begin : request_source
    cers_pkg::request_t rq;
    stim_row_t          row;
    rst = 1'b1;
    request.valid = 1'b0;
    request.data = '0;
    mismatches = 0;
    cycle_count = 0;
    long_hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero energy: kappa underflows, eps is one and the sample is kept
    row = mk_row('0, '1, '1, '1);
    row.known = 1'b1;
    row.res = '{accepted: 1'b1, energy_ratio: 31'(FX1), one_minus_cosine: '0,
                sine_squared: '0};
    add_row(row);
    // smallest and largest energies with extreme random fractions
    add_row(mk_row(48'd1, '0, '0, '0));
    add_row(mk_row(48'd1, '1, '1, '1));
    add_row(mk_row('1, '0, '0, '0));
    add_row(mk_row('1, '1, '1, '1));
    add_row(mk_row('1, '0, '1, '0));
    add_row(mk_row('1, '1, '0, '1));
    // near the electron mass and at other energies: both branches, ratio near floor and ceiling
    add_row(mk_row(48'd510999, 32'h0000_0001, 32'h8000_0000, 32'h0));
    add_row(mk_row(48'd510999, 32'hFFFF_FFFE, 32'h8000_0000, 32'h0));
    add_row(mk_row(48'd1000000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    add_row(mk_row(48'd1000, 32'hC000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
    add_row(mk_row(48'd1000000000, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0));
    add_row(mk_row(48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1));
    add_row(mk_row(48'h8000_0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    add_row(mk_row(48'h5555_5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    add_row(mk_row(48'h0000_0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));

    foreach (stim_table[i]) begin
      row = stim_table[i];
      offer_request(row.req, row.known ? row.res : predict_sample(row.req));
    end

    // sender pauses until every outstanding result has been taken
    request.valid <= 1'b0;
    @(posedge clk);
    wait_for_drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      // mid-run, hold the output off while requests keep coming
      if (n == N_RANDOM / 3) long_hold_req = 1'b1;
      rq.photon_energy = draw_energy();
      rq.uniform_one   = $urandom;
      rq.uniform_two   = $urandom;
      rq.uniform_three = $urandom;
      offer_request(rq, predict_sample(rq));
    end
    request.valid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cers_pkg.sv
hw/rtl/cers_if.sv
hw/rtl/cers_log2.sv
hw/rtl/cers_div.sv
hw/rtl/cers_exp2.sv
hw/rtl/cers_sqrt.sv
hw/rtl/compton_energy_rejection_sampler.sv
bench/tb_top.sv
